// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on clk, held off while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked every clock outside reset
`define U8VT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define U8VT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- sv/u8vt_pkg.sv -----
// ----------------------------------------------------------------------------
// u8vt_pkg
// shared types, constants and lead byte decode for the utf-8 validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8vt_pkg;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int LEN_W         = $clog2(MAX_SEQ_BYTES + 1);
  localparam int SEQ_IDX_W     = $clog2(MAX_SEQ_BYTES);
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED  = 2'd1;
  localparam logic [1:0] KIND_ILLEGAL   = 2'd2;
  localparam logic [1:0] KIND_CUT_SHORT = 2'd3;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [15:0] MAX_CHARS_RESET = 16'hFFFF;

  // lead class boundaries
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD5_MIN   = 8'hF8;
  localparam logic [7:0] LEAD6_MIN   = 8'hFC;
  localparam logic [7:0] LEAD_BAD_HI = 8'hFE;

  // overlong limits: lead below *_LEAD needs second byte at least *_SECOND
  localparam logic [7:0] OVL3_LEAD   = 8'hE1;
  localparam logic [7:0] OVL3_SECOND = 8'hA0;
  localparam logic [7:0] OVL4_LEAD   = 8'hF1;
  localparam logic [7:0] OVL4_SECOND = 8'h90;
  localparam logic [7:0] OVL5_LEAD   = 8'hF9;
  localparam logic [7:0] OVL5_SECOND = 8'h88;
  localparam logic [7:0] OVL6_LEAD   = 8'hFD;
  localparam logic [7:0] OVL6_SECOND = 8'h84;

  localparam logic [7:0] CONT_MIN = 8'h80;
  localparam logic [7:0] CONT_MAX = 8'hBF;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // one character or one status, as queued between front and back
  typedef struct packed {
    logic [1:0]                          kind;
    logic [LEN_W-1:0]                    len;
    logic [MAX_SEQ_BYTES-1:0][7:0]       bytes;
  } job_t;

  // character length from lead byte, 0 for an illegal lead
  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
    logic [LEN_W-1:0] n;
    if (b < CONT_MIN)         n = LEN_W'(1);
    else if (b < LEAD2_MIN)   n = LEN_W'(0);
    else if (b < LEAD3_MIN)   n = LEN_W'(2);
    else if (b < LEAD4_MIN)   n = LEN_W'(3);
    else if (b < LEAD5_MIN)   n = LEN_W'(4);
    else if (b < LEAD6_MIN)   n = LEN_W'(5);
    else if (b < LEAD_BAD_HI) n = LEN_W'(6);
    else                      n = LEN_W'(0);
    return n;
  endfunction

endpackage

// ----- sv/u8vt_front.sv -----
// ----------------------------------------------------------------------------
// u8vt_front
// gathers bytes into characters, validates them and queues output jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8vt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  u8vt_pkg::in_item_t din,
  input  logic [15:0]        max_chars,
  output logic               job_push,
  output u8vt_pkg::job_t     job
);

  localparam int LW = u8vt_pkg::LEN_W;
  localparam int IW = u8vt_pkg::SEQ_IDX_W;

  logic [u8vt_pkg::MAX_SEQ_BYTES-1:0][7:0] seq_bytes, seq_bytes_next;
  logic [LW-1:0] seq_need, seq_need_next;
  logic [LW-1:0] seq_have, seq_have_next;
  logic [15:0]   chars_seen, chars_seen_next;
  logic          error_latched, error_latched_next;
  logic          bad, bad_next;

  logic [LW-1:0] lead_n;
  logic [LW-1:0] char_len;
  logic          complete;
  logic          overlong;
  logic [7:0]    b;

  assign b      = din.in_byte;
  assign lead_n = u8vt_pkg::lead_length(b);

  // overlong test on the second byte, by character length
  always_comb begin
    case (seq_need)
      LW'(3):  overlong = (seq_bytes[0] < u8vt_pkg::OVL3_LEAD) && (b < u8vt_pkg::OVL3_SECOND);
      LW'(4):  overlong = (seq_bytes[0] < u8vt_pkg::OVL4_LEAD) && (b < u8vt_pkg::OVL4_SECOND);
      LW'(5):  overlong = (seq_bytes[0] < u8vt_pkg::OVL5_LEAD) && (b < u8vt_pkg::OVL5_SECOND);
      LW'(6):  overlong = (seq_bytes[0] < u8vt_pkg::OVL6_LEAD) && (b < u8vt_pkg::OVL6_SECOND);
      default: overlong = 1'b0;
    endcase
  end

  always_comb begin
    seq_bytes_next     = seq_bytes;
    seq_need_next      = seq_need;
    seq_have_next      = seq_have;
    chars_seen_next    = chars_seen;
    error_latched_next = error_latched;
    bad_next           = bad;
    complete           = 1'b0;
    char_len           = seq_need;
    job_push           = 1'b0;
    job                = '0;

    if (in_fire) begin
      if (din.operation == u8vt_pkg::OP_END) begin
        job_push = 1'b1;
        job.len  = LW'(1);
        if (error_latched)        job.kind = u8vt_pkg::KIND_ILLEGAL;
        else if (seq_need != '0)  job.kind = u8vt_pkg::KIND_CUT_SHORT;
        else                      job.kind = u8vt_pkg::KIND_ACCEPTED;
        seq_need_next      = '0;
        seq_have_next      = '0;
        chars_seen_next    = '0;
        error_latched_next = 1'b0;
      end else if (!error_latched) begin
        if (seq_need == '0) begin
          // lead byte
          if (lead_n == '0 || lead_n > LW'(u8vt_pkg::MAX_SEQ_BYTES)) begin
            error_latched_next = 1'b1;
          end else begin
            seq_bytes_next[0] = b;
            seq_have_next     = LW'(1);
            seq_need_next     = lead_n;
            bad_next          = 1'b0;
            char_len          = lead_n;
            complete          = (lead_n == LW'(1));
          end
        end else begin
          // continuation byte
          seq_bytes_next[seq_have[IW-1:0]] = b;
          if (b < u8vt_pkg::CONT_MIN || b > u8vt_pkg::CONT_MAX) bad_next = 1'b1;
          if (seq_have == LW'(1) && overlong) bad_next = 1'b1;
          seq_have_next = seq_have + LW'(1);
          complete      = (seq_have + LW'(1) == seq_need);
        end

        if (complete) begin
          seq_need_next = '0;
          seq_have_next = '0;
          if (bad_next) begin
            error_latched_next = 1'b1;
          end else if (chars_seen < max_chars) begin
            job_push        = 1'b1;
            job.kind        = u8vt_pkg::KIND_DATA;
            job.len         = char_len;
            job.bytes       = seq_bytes_next;
            chars_seen_next = chars_seen + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_bytes <= seq_bytes_next;
    bad       <= bad_next;
    if (rst) begin
      seq_need      <= '0;
      seq_have      <= '0;
      chars_seen    <= '0;
      error_latched <= 1'b0;
    end else begin
      seq_need      <= seq_need_next;
      seq_have      <= seq_have_next;
      chars_seen    <= chars_seen_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

// ----- sv/u8vt_queue.sv -----
// ----------------------------------------------------------------------------
// u8vt_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8vt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  u8vt_pkg::job_t wr_job,
  input  logic           rd_en,
  output u8vt_pkg::job_t rd_job,
  output logic           q_full,
  output logic           q_empty
);

  localparam int PW = u8vt_pkg::Q_PTR_W;
  localparam int CW = $clog2(u8vt_pkg::Q_DEPTH + 1);

  u8vt_pkg::job_t mem [u8vt_pkg::Q_DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(u8vt_pkg::Q_DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(u8vt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PW'(u8vt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (wr_en && !rd_en)      count <= count + CW'(1);
      else if (rd_en && !wr_en) count <= count - CW'(1);
    end
  end

endmodule

// ----- sv/u8vt_back.sv -----
// ----------------------------------------------------------------------------
// u8vt_back
// unrolls queued jobs into results, one per cycle while results are popped, behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8vt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  u8vt_pkg::job_t      q_job,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output u8vt_pkg::out_item_t dout
);

  localparam int LW = u8vt_pkg::LEN_W;
  localparam int IW = u8vt_pkg::SEQ_IDX_W;

  logic [IW-1:0] idx;
  logic          out_valid;
  logic          load;
  logic          is_last;

  assign empty   = !out_valid;
  assign load    = q_valid && (!out_valid || pop);
  assign is_last = (LW'(idx) + LW'(1) == q_job.len);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      dout.out_byte <= q_job.bytes[idx];
      dout.kind     <= q_job.kind;
      dout.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) idx <= is_last ? '0 : idx + IW'(1);
    end
  end

endmodule

// ----- sv/utf8_validate_truncate.sv -----
// ----------------------------------------------------------------------------
// utf8_validate_truncate
// utf-8 validator that passes through the first max_chars characters
// ----------------------------------------------------------------------------
// Strings come in one byte per request, closed by an end-of-string request.
// The front end takes one request per cycle while the queue is not full:
// it sorts lead bytes by class, gathers the continuation bytes, checks
// their range and the overlong forms, and on a good character (while fewer
// than max_chars went out) queues it as one job; every end request queues
// one status job (accepted, illegal, or cut short). The back end unrolls
// a job into results, one per cycle while the output register is popped.
// A two-entry job queue sits between the halves; full is high while both
// entries are taken, which is the only input stall. Once a string is
// illegal its remaining data bytes are dropped until the end request.
// Bytes sent before a later error are not withdrawn. max_chars resets to
// 65535 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_validate_truncate (
  input  logic                clk,
  input  logic                rst,
  // input side
  input  logic                push,
  output logic                full,
  input  u8vt_pkg::in_item_t  din,
  // result side
  output logic                empty,
  input  logic                pop,
  output u8vt_pkg::out_item_t dout,
  // configuration
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);

  logic [15:0]    max_chars;   // characters passed before truncation
  logic           in_fire;     // input request taken this cycle
  logic           job_push;    // front queues a character or status
  u8vt_pkg::job_t job;
  u8vt_pkg::job_t head_job;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= u8vt_pkg::MAX_CHARS_RESET;
    end else if (cfg_we) begin
      max_chars <= cfg_data;
    end
  end

  // input stalls only on a full job queue
  assign full    = q_full;
  assign in_fire = push && !full;

  // front: classify, gather, validate, count characters
  u8vt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .din       (din),
    .max_chars (max_chars),
    .job_push  (job_push),
    .job       (job)
  );

  // job queue decoupling front and back
  u8vt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back: one result per cycle into the output register while results are popped
  u8vt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .dout    (dout)
  );

  // front never writes into a full queue
  `U8VT_NEVER(a_no_push_when_full, job_push && q_full, "job queued while queue full")

  // every end request yields a status job
  `U8VT_ASSERT(a_end_makes_job, (in_fire && din.operation == u8vt_pkg::OP_END) |-> job_push, "end request without status job")

  // status results are single, zero-byte and marked last
  `U8VT_ASSERT(a_status_shape, (!empty && dout.kind != u8vt_pkg::KIND_DATA) |-> (dout.last && dout.out_byte == 8'd0), "malformed status result")

endmodule
